[sv/agc_pkg.sv]
// shared types, constants and helpers for the alignment gap compactor
// no dependencies; imported by every module of the block
package agc_pkg;

    localparam int unsigned MAX_LEN = 65536;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned LBP_W   = $clog2(MAX_LEN);
    localparam int unsigned RUN_W   = 8;
    localparam int unsigned CHAR_W  = 8;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);
    localparam logic [POS_W-1:0] IDX_LIMIT = POS_W'(MAX_LEN - 1);
    localparam logic [RUN_W-1:0] RUN_LIMIT = {RUN_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    localparam logic KIND_BASE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // one result beat
    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] base_char;
        logic [POS_W-1:0]  comp_index;
        logic [POS_W-1:0]  expd_pos;
        logic [POS_W-1:0]  gaps_before;
        logic [RUN_W-1:0]  point_runs;
        logic              last_out;
    } rec_t;

    // record handoff between the step logic and the output register
    typedef struct packed {
        logic valid;
        rec_t rec;
    } rec_beat_t;

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

endpackage

[sv/alignment_gap_compactor_top.sv]
// top level of the alignment gap compactor
// depends on agc_pkg, agc_step and agc_out_stage
//
// usage
//   input channel: one aligned character per beat (ch, last_in) on in_valid/in_ready;
//   last_in marks the final character of a sequence
//   output channel: record beats on out_valid/out_ready; kind 0 is a base record,
//   kind 1 the end record that closes a sequence; last_out flags the final
//   record caused by one input beat
//   '-' and '.' are gaps and give no record unless marked last
// path: a record is built from the input register and loaded into the result register;
//   the end record that follows a base marked last comes right after that base record
// throughput: one input beat per cycle while the output does not stall; a base marked last
//   yields two records and holds the input register until both are taken, one per output
//   beat, since the result register takes one record per cycle
// reset: asynchronous, active low; clears counters, run tracking and both
//   valid flags; sequence state also returns to zero after each end record
// stall: while out_ready is low the result register holds its record; the
//   input register still takes a beat if empty, and gap characters that are
//   not last pass through it without needing the output
module alignment_gap_compactor_top
    import agc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] ch,
    input  logic              last_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic [CHAR_W-1:0] base_char,
    output logic [POS_W-1:0]  comp_index,
    output logic [POS_W-1:0]  expd_pos,
    output logic [POS_W-1:0]  gaps_before,
    output logic [RUN_W-1:0]  point_runs,
    output logic              last_out
);

    rec_beat_t beat;
    logic      beat_take;
    rec_t      rec;

    // character decode, sequence counters and record build
    agc_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last_in   (last_in),
        .beat      (beat),
        .beat_take (beat_take)
    );

    // result register toward the receiver
    agc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .beat_take (beat_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rec       (rec)
    );

    assign kind        = rec.kind;
    assign base_char   = rec.base_char;
    assign comp_index  = rec.comp_index;
    assign expd_pos    = rec.expd_pos;
    assign gaps_before = rec.gaps_before;
    assign point_runs  = rec.point_runs;
    assign last_out    = rec.last_out;

    // an end record always closes the input beat that caused it
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_END |-> last_out)
        else $error("end record without last_out");

    // a base position never passes the saturation limit
    a_base_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BASE |-> expd_pos <= IDX_LIMIT)
        else $error("base position beyond limit");

    // below the saturated position a base never has more bases before it than positions
    a_base_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BASE && expd_pos != IDX_LIMIT |-> comp_index <= expd_pos)
        else $error("base index exceeds position");

    // end record tail fits inside the sequence length and has no runs
    a_end_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_END |-> gaps_before <= expd_pos && point_runs == '0)
        else $error("end record tail out of range");

endmodule

[sv/agc_step.sv]
// input register, sequence state and per-character record logic
// depends on agc_pkg
module agc_step
    import agc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] ch,
    input  logic              last_in,
    output rec_beat_t         beat,
    input  logic              beat_take
);

    logic              s1_valid_reg, s1_valid_next;
    logic              phase_reg, phase_next;
    logic [CHAR_W-1:0] ch_reg;
    logic              last_reg;

    logic [POS_W-1:0]  base_count_reg, base_count_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [LBP_W-1:0]  last_base_pos_reg, last_base_pos_next;
    logic              seen_base_reg, seen_base_next;
    logic              in_point_run_reg, in_point_run_next;
    logic [RUN_W-1:0]  run_count_reg, run_count_next;

    // state after applying the held character
    logic [POS_W-1:0]  u_base_count, u_position;
    logic [LBP_W-1:0]  u_last_base_pos;
    logic              u_seen_base, u_in_point_run;
    logic [RUN_W-1:0]  u_run_count;

    logic              is_dash, is_point, is_base;
    logic [POS_W-1:0]  idx, base_gaps;
    logic [POS_W-1:0]  e_count, e_pos, e_tail;
    logic [LBP_W-1:0]  e_lbp;
    logic              e_seen;
    logic              need_out, fire, release_s1, split;
    rec_t              base_rec, end_rec;

    assign is_dash  = (ch_reg == CH_DASH);
    assign is_point = (ch_reg == CH_POINT);
    assign is_base  = !is_dash && !is_point;
    assign idx      = (position_reg < POS_LIMIT) ? position_reg : IDX_LIMIT;

    always_comb
    begin
        u_base_count    = base_count_reg;
        u_position      = (position_reg < POS_LIMIT) ? position_reg + 1'b1 : position_reg;
        u_last_base_pos = last_base_pos_reg;
        u_seen_base     = seen_base_reg;
        u_in_point_run  = in_point_run_reg;
        u_run_count     = run_count_reg;
        if (is_dash)
        begin
            u_in_point_run = 1'b0;
        end
        else if (is_point)
        begin
            if (!in_point_run_reg)
            begin
                u_in_point_run = 1'b1;
                if (seen_base_reg && run_count_reg != RUN_LIMIT)
                begin
                    u_run_count = run_count_reg + 1'b1;
                end
            end
        end
        else
        begin
            if (base_count_reg < POS_LIMIT)
            begin
                u_base_count = base_count_reg + 1'b1;
            end
            u_last_base_pos = idx[LBP_W-1:0];
            u_seen_base     = 1'b1;
            u_in_point_run  = 1'b0;
            u_run_count     = '0;
        end
    end

    // gaps since the previous base, or since the sequence start before the first base
    always_comb
    begin
        if (!seen_base_reg)
        begin
            base_gaps = idx;
        end
        else if (idx > {1'b0, last_base_pos_reg})
        begin
            base_gaps = idx - {1'b0, last_base_pos_reg} - 1'b1;
        end
        else
        begin
            base_gaps = '0;
        end
    end

    // end record reads the state once the last character is applied
    assign e_count = phase_reg ? base_count_reg    : u_base_count;
    assign e_pos   = phase_reg ? position_reg      : u_position;
    assign e_lbp   = phase_reg ? last_base_pos_reg : u_last_base_pos;
    assign e_seen  = phase_reg ? seen_base_reg     : u_seen_base;
    assign e_tail  = e_seen ? e_pos - {1'b0, e_lbp} : '0;

    always_comb
    begin
        base_rec.kind        = KIND_BASE;
        base_rec.base_char   = to_upper(ch_reg);
        base_rec.comp_index  = base_count_reg;
        base_rec.expd_pos    = idx;
        base_rec.gaps_before = base_gaps;
        base_rec.point_runs  = run_count_reg;
        base_rec.last_out    = !last_reg;

        end_rec.kind         = KIND_END;
        end_rec.base_char    = '0;
        end_rec.comp_index   = e_count;
        end_rec.expd_pos     = e_pos;
        end_rec.gaps_before  = e_tail;
        end_rec.point_runs   = '0;
        end_rec.last_out     = 1'b1;
    end

    assign need_out   = phase_reg || is_base || last_reg;
    assign beat.valid = s1_valid_reg && need_out;
    assign beat.rec   = (phase_reg || !is_base) ? end_rec : base_rec;
    assign fire       = s1_valid_reg && (!need_out || beat_take);
    // base marked last holds the slot until its end record is taken
    assign split      = !phase_reg && is_base && last_reg;
    assign release_s1 = fire && !split;
    assign in_ready   = !s1_valid_reg || release_s1;

    always_comb
    begin
        s1_valid_next      = s1_valid_reg;
        phase_next         = phase_reg;
        base_count_next    = base_count_reg;
        position_next      = position_reg;
        last_base_pos_next = last_base_pos_reg;
        seen_base_next     = seen_base_reg;
        in_point_run_next  = in_point_run_reg;
        run_count_next     = run_count_reg;
        if (fire)
        begin
            if (phase_reg || last_reg && !split)
            begin
                base_count_next    = '0;
                position_next      = '0;
                last_base_pos_next = '0;
                seen_base_next     = 1'b0;
                in_point_run_next  = 1'b0;
                run_count_next     = '0;
                phase_next         = 1'b0;
            end
            else
            begin
                base_count_next    = u_base_count;
                position_next      = u_position;
                last_base_pos_next = u_last_base_pos;
                seen_base_next     = u_seen_base;
                in_point_run_next  = u_in_point_run;
                run_count_next     = u_run_count;
                phase_next         = split;
            end
        end
        if (release_s1)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            phase_reg         <= 1'b0;
            base_count_reg    <= '0;
            position_reg      <= '0;
            last_base_pos_reg <= '0;
            seen_base_reg     <= 1'b0;
            in_point_run_reg  <= 1'b0;
            run_count_reg     <= '0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            phase_reg         <= phase_next;
            base_count_reg    <= base_count_next;
            position_reg      <= position_next;
            last_base_pos_reg <= last_base_pos_next;
            seen_base_reg     <= seen_base_next;
            in_point_run_reg  <= in_point_run_next;
            run_count_reg     <= run_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg   <= ch;
            last_reg <= last_in;
        end
    end

endmodule

[sv/agc_out_stage.sv]
// result register holding one record beat toward the receiver
// depends on agc_pkg
module agc_out_stage
    import agc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rec_beat_t beat,
    output logic      beat_take,
    output logic      out_valid,
    input  logic      out_ready,
    output rec_t      rec
);

    logic out_valid_reg, out_valid_next;
    rec_t rec_reg;
    logic load;

    assign beat_take = !out_valid_reg || out_ready;
    assign load      = beat.valid && beat_take;
    assign out_valid = out_valid_reg;
    assign rec       = rec_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= beat.rec;
        end
    end

endmodule

[verif/alignment_gap_compactor_checker.sv]
// checker for the alignment gap compactor: watches both channels, predicts the records
// of every accepted character beat and compares them with the result beats
// depends on agc_pkg
module alignment_gap_compactor_checker
    import agc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [CHAR_W-1:0] ch,
    input  logic              last_in,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              kind,
    input  logic [CHAR_W-1:0] base_char,
    input  logic [POS_W-1:0]  comp_index,
    input  logic [POS_W-1:0]  expd_pos,
    input  logic [POS_W-1:0]  gaps_before,
    input  logic [RUN_W-1:0]  point_runs,
    input  logic              last_out,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // sequence state of the predictor
    logic [POS_W-1:0] seq_bases;
    logic [POS_W-1:0] seq_pos;
    logic [LBP_W-1:0] prev_base_pos;
    logic             had_base;
    logic             in_dots;
    logic [RUN_W-1:0] dot_runs;

    rec_t expected_recs[$];
    rec_t got_rec;
    rec_t want_rec;
    int   fail_total;

    function automatic string rec_text(input rec_t r);
        return $sformatf("kind=%0d char=%02h index=%0d pos=%0d gaps=%0d runs=%0d last=%0d",
                         r.kind, r.base_char, r.comp_index, r.expd_pos, r.gaps_before,
                         r.point_runs, r.last_out);
    endfunction

    task automatic clear_sequence();
        seq_bases     = '0;
        seq_pos       = '0;
        prev_base_pos = '0;
        had_base      = 1'b0;
        in_dots       = 1'b0;
        dot_runs      = '0;
    endtask

    // one character: update the sequence state, queue the records it causes
    task automatic compact_char(input logic [CHAR_W-1:0] c, input logic closes);
        logic [POS_W-1:0] idx;
        logic [POS_W-1:0] gaps;
        rec_t             r;
        idx = (seq_pos < POS_LIMIT) ? seq_pos : IDX_LIMIT;
        if (c == CH_DASH)
        begin
            in_dots = 1'b0;
        end
        else if (c == CH_POINT)
        begin
            if (!in_dots)
            begin
                in_dots = 1'b1;
                // runs ahead of the first base are dropped
                if (had_base && dot_runs != RUN_LIMIT)
                    dot_runs++;
            end
        end
        else
        begin
            if (!had_base)
                gaps = idx;
            else if (idx > {1'b0, prev_base_pos})
                gaps = idx - {1'b0, prev_base_pos} - 1'b1;
            else
                gaps = '0;
            r.kind        = KIND_BASE;
            r.base_char   = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c;
            r.comp_index  = seq_bases;
            r.expd_pos    = idx;
            r.gaps_before = gaps;
            r.point_runs  = dot_runs;
            r.last_out    = !closes;
            expected_recs.push_back(r);
            if (seq_bases < POS_LIMIT)
                seq_bases++;
            prev_base_pos = idx[LBP_W-1:0];
            had_base      = 1'b1;
            in_dots       = 1'b0;
            dot_runs      = '0;
        end
        if (seq_pos < POS_LIMIT)
            seq_pos++;
        if (closes)
        begin
            r.kind        = KIND_END;
            r.base_char   = '0;
            r.comp_index  = seq_bases;
            r.expd_pos    = seq_pos;
            r.gaps_before = had_base ? seq_pos - {1'b0, prev_base_pos} : '0;
            r.point_runs  = '0;
            r.last_out    = 1'b1;
            expected_recs.push_back(r);
            clear_sequence();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sequence();
            expected_recs.delete();
            fail_total = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_rec = {kind, base_char, comp_index, expd_pos, gaps_before, point_runs,
                           last_out};
                if (expected_recs.size() == 0)
                begin
                    if (fail_total < REPORT_LIMIT)
                        $display("%0t: unexpected record %s", $time, rec_text(got_rec));
                    fail_total++;
                end
                else
                begin
                    want_rec = expected_recs.pop_front();
                    if (got_rec.kind !== want_rec.kind
                        || got_rec.base_char !== want_rec.base_char
                        || got_rec.comp_index !== want_rec.comp_index
                        || got_rec.expd_pos !== want_rec.expd_pos
                        || got_rec.gaps_before !== want_rec.gaps_before
                        || got_rec.point_runs !== want_rec.point_runs
                        || got_rec.last_out !== want_rec.last_out)
                    begin
                        if (fail_total < REPORT_LIMIT)
                            $display("%0t: mismatch, expected %s, got %s", $time,
                                     rec_text(want_rec), rec_text(got_rec));
                        fail_total++;
                    end
                end
            end
            if (in_valid && in_ready)
                compact_char(ch, last_in);
        end
        fail_count <= fail_total;
        pending    <= expected_recs.size();
    end

endmodule

[verif/alignment_gap_compactor_top_tb.sv]
// testbench top for the alignment gap compactor: clock, reset, character stimulus,
// receiver pacing and the verdict; depends on agc_pkg, the block and
// alignment_gap_compactor_checker
module alignment_gap_compactor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import agc_pkg::*;

    // pacing of the two channels
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 220;    // per pacing phase

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CHAR_W-1:0] ch;
    logic              last_in;
    logic              out_valid;
    logic              out_ready;
    logic              kind;
    logic [CHAR_W-1:0] base_char;
    logic [POS_W-1:0]  comp_index;
    logic [POS_W-1:0]  expd_pos;
    logic [POS_W-1:0]  gaps_before;
    logic [RUN_W-1:0]  point_runs;
    logic              last_out;
    logic              hold_req;
    pace_t             pace;
    int                fail_count;
    int                pending;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    alignment_gap_compactor_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .base_char   (base_char),
        .comp_index  (comp_index),
        .expd_pos    (expd_pos),
        .gaps_before (gaps_before),
        .point_runs  (point_runs),
        .last_out    (last_out)
    );

    alignment_gap_compactor_checker i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .base_char   (base_char),
        .comp_index  (comp_index),
        .expd_pos    (expd_pos),
        .gaps_before (gaps_before),
        .point_runs  (point_runs),
        .last_out    (last_out),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    function automatic logic sender_idles();
        case (pace)
            PACE_SENDER_IDLE: return $urandom_range(99) < 82;
            PACE_BOTH:        return $urandom_range(99) < 14;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (pace)
            PACE_RECEIVER_STALL: return $urandom_range(99) < 82;
            PACE_BOTH:           return $urandom_range(99) < 14;
            default:             return 1'b0;
        endcase
    endfunction

    // any byte that is not a gap
    function automatic logic [CHAR_W-1:0] random_base();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(255));
        while (c == CH_DASH || c == CH_POINT);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] random_gap();
        return $urandom_range(1) ? CH_POINT : CH_DASH;
    endfunction

    // weighted toward gaps and letters so that point runs and case folding
    // show up often; any byte at all now and then
    function automatic logic [CHAR_W-1:0] random_char();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return CH_POINT;
        else if (pick < 5)
            return CH_DASH;
        else if (pick < 8)
            return CHAR_W'($urandom_range(1) ? $urandom_range(8'h61, 8'h7A)
                                             : $urandom_range(8'h41, 8'h5A));
        else
            return CHAR_W'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one character beat and return at the edge that takes it;
    // valid stays up across back-to-back beats
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic closes);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        last_in  <= closes;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // whole string as one sequence, last flag on its final character
    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // sender pauses until every predicted record has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // random sequences with random content; now and then one made of gaps only
    task automatic run_random(input int n_items);
        int   sent;
        int   len;
        int   i;
        logic gaps_only;
        sent = 0;
        while (sent < n_items)
        begin
            len       = ($urandom_range(9) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 12);
            gaps_only = ($urandom_range(9) == 0);
            for (i = 0; i < len; i++)
                send_char(gaps_only ? random_gap() : random_char(), i == len - 1);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stalls, plus a long hold-off on request that
    // is counted here so the sender can keep pushing meanwhile
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= !receiver_stalls();
            end
        end
    end

    // ------------------------------------------------------------------
    // main stimulus and verdict
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        ch       = '0;
        last_in  = 1'b0;
        hold_req = 1'b0;
        pace     = PACE_FULL;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: leading run dropped, two runs split by a dash, lowercase
        // and uppercase letters, trailing run never reported
        send_text("..-.a.-..Z-z.-");
        // single base that is also last: base record then end record
        send_char(8'hFF, 1'b1);
        // sequences without any base
        send_text(".");
        send_text("-");
        // zero byte and the neighbors of the letter and gap codes
        send_char(8'h00, 1'b0);
        send_text("`{@[,/");
        drain();

        // point-run count saturates
        send_char(random_base(), 1'b0);
        repeat (257)
        begin
            send_char(CH_POINT, 1'b0);
            send_char(CH_DASH, 1'b0);
        end
        send_char(random_base(), 1'b1);
        drain();

        // random part at full rate, opening with a long receiver hold-off so
        // the block backs up and stalls its input
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        run_random(RANDOM_ITEMS);
        drain();

        pace <= PACE_SENDER_IDLE;
        run_random(RANDOM_ITEMS);
        drain();

        pace <= PACE_RECEIVER_STALL;
        run_random(RANDOM_ITEMS);
        drain();

        pace <= PACE_BOTH;
        run_random(RANDOM_ITEMS);
        drain();

        // quiet tail to catch stray records
        pace <= PACE_FULL;
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit: ends the run with a failure if the stimulus has not finished
    initial
    begin
        #(400_000);
        $display("tb: failure");
        $finish;
    end

endmodule

[alignment_gap_compactor_top.f]
sv/agc_pkg.sv
sv/agc_step.sv
sv/agc_out_stage.sv
sv/alignment_gap_compactor_top.sv
verif/alignment_gap_compactor_checker.sv
verif/alignment_gap_compactor_top_tb.sv
